[design/compacting_vector_table_defines.svh]
// Assertion macros used by the port-level checker of the vector table.
`ifndef COMPACTING_VECTOR_TABLE_DEFINES_SVH
`define COMPACTING_VECTOR_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define CVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cvt_pkg.sv]
// Shared constants, codes and control types of the compacting vector table.
package cvt_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 7;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [ACTION_W-1:0] ACT_APPEND     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_AT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_ALL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SHOW       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Find reports -1 when the value is absent.
  localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHOW_READ,
    S_SHOW_EMIT,
    S_REPLY
  } cvt_state_t;

  typedef struct packed {
    logic load_req;
    logic dispatch;
    logic scan;
    logic finish_scan;
    logic show_rd;
    logic emit_elem;
    logic emit_reply;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                list_empty;
    logic                pos_bad;
    logic                out_free;
    logic                scan_done;
    logic                show_last;
  } dp_sts_t;

endpackage

[design/cvt_req_if.sv]
// Request channel of the vector table: handshake plus request payload.
interface cvt_req_if;
  import cvt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [ACTION_W-1:0] action;
  logic signed [VALUE_W-1:0]  value;
  logic        [POS_W-1:0]    position_in;

  modport source (output valid, output action, output value, output position_in,
                  input ready);
  modport sink   (input valid, input action, input value, input position_in,
                  output ready);
endinterface

[design/cvt_rsp_if.sv]
// Result channel of the vector table: handshake plus result payload.
interface cvt_rsp_if;
  import cvt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [FOUND_W-1:0]  found_position;
  logic signed [VALUE_W-1:0]  element;
  logic                       is_empty;
  logic                       last;
  logic        [COUNT_W-1:0]  count_out;

  modport source (output valid, output status, output found_position, output element,
                  output is_empty, output last, output count_out, input ready);
  modport sink   (input valid, input status, input found_position, input element,
                  input is_empty, input last, input count_out, output ready);
endinterface

[design/cvt_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module cvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cvt_pkg::dp_sts_t  sts,
  output cvt_pkg::dp_cmd_t  cmd
);
  import cvt_pkg::*;

  cvt_state_t state;
  cvt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (sts.action)
          ACT_FIND, ACT_REMOVE_ALL: state_next = S_SCAN;
          ACT_REMOVE_AT:            state_next = sts.pos_bad ? S_REPLY : S_SCAN;
          ACT_SHOW:                 state_next = sts.list_empty ? S_REPLY : S_SHOW_READ;
          default:                  state_next = S_REPLY;
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.finish_scan = 1'b1;
          state_next      = S_REPLY;
        end
      end
      S_SHOW_READ: begin
        cmd.show_rd = 1'b1;
        state_next  = S_SHOW_EMIT;
      end
      S_SHOW_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_elem = 1'b1;
          state_next    = sts.show_last ? S_IDLE : S_SHOW_READ;
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit_reply = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/cvt_datapath.sv]
// Datapath: entry memory, count, scan pointers, request and result registers.
module cvt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cvt_pkg::dp_cmd_t                    cmd,
  output cvt_pkg::dp_sts_t                    sts,
  input  logic        [cvt_pkg::ACTION_W-1:0] action_in,
  input  logic signed [cvt_pkg::VALUE_W-1:0]  value_in,
  input  logic        [cvt_pkg::POS_W-1:0]    position_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [cvt_pkg::STATUS_W-1:0] out_status,
  output logic signed [cvt_pkg::FOUND_W-1:0]  out_found,
  output logic signed [cvt_pkg::VALUE_W-1:0]  out_element,
  output logic                                out_empty,
  output logic                                out_last,
  output logic        [cvt_pkg::COUNT_W-1:0]  out_count
);
  import cvt_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  value;
  logic [POS_W-1:0]    position;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    wr_idx;
  logic [CNT_W-1:0]    proc_idx;
  logic                rd_pend;
  logic [VALUE_W-1:0]  rd_data;
  logic                hit;
  logic [FOUND_W-1:0]  found;
  logic [STATUS_W-1:0] status;

  logic               full;
  logic               pos_bad;
  logic               scan_issue;
  logic               keep;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [CNT_W-1:0]   pos_plus1;

  assign full       = (count == CNT_W'(DEPTH));
  assign pos_bad    = (CMP_W'(position) >= CMP_W'(count));
  assign pos_plus1  = CNT_W'(CMP_W'(position) + CMP_W'(1));
  assign scan_issue = cmd.scan && (rd_idx < count);
  assign keep       = (action == ACT_REMOVE_AT) || (rd_data != value);
  assign rd_en      = scan_issue || cmd.show_rd;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[IDX_W-1:0];
    wr_data = rd_data;
    if (cmd.dispatch) begin
      wr_en   = (action == ACT_APPEND) && !full;
      wr_addr = count[IDX_W-1:0];
      wr_data = value;
    end else if (cmd.scan && rd_pend && keep && (action != ACT_FIND)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  assign sts.action     = action;
  assign sts.list_empty = (count == '0);
  assign sts.pos_bad    = pos_bad;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.scan_done  = !rd_pend && (rd_idx >= count);
  assign sts.show_last  = (rd_idx == count);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= scan_issue;
      if (cmd.dispatch && (action == ACT_APPEND) && !full) begin
        count <= count + CNT_W'(1);
      end else if (cmd.finish_scan && (action == ACT_REMOVE_ALL)) begin
        count <= wr_idx;
      end else if (cmd.finish_scan && (action == ACT_REMOVE_AT)) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.emit_elem || cmd.emit_reply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      action   <= action_in;
      value    <= value_in;
      position <= position_in;
    end
    if (cmd.dispatch) begin
      hit    <= 1'b0;
      found  <= (action == ACT_FIND) ? FOUND_NONE : '0;
      status <= STATUS_OK;
      if ((action == ACT_APPEND) && full) begin
        status <= STATUS_FULL;
      end else if ((action == ACT_REMOVE_AT) && pos_bad) begin
        status <= STATUS_RANGE;
      end
      proc_idx <= '0;
      if (action == ACT_REMOVE_AT) begin
        rd_idx <= pos_plus1;
        wr_idx <= CNT_W'(position);
      end else begin
        rd_idx <= '0;
        wr_idx <= '0;
      end
    end else begin
      if (scan_issue || cmd.show_rd) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (cmd.scan && rd_pend) begin
        proc_idx <= proc_idx + CNT_W'(1);
        if ((action == ACT_FIND) && !hit && (rd_data == value)) begin
          hit   <= 1'b1;
          found <= FOUND_W'(proc_idx);
        end
        if (wr_en) begin
          wr_idx <= wr_idx + CNT_W'(1);
        end
      end
    end
    if (cmd.emit_elem) begin
      out_status  <= STATUS_OK;
      out_found   <= '0;
      out_element <= rd_data;
      out_empty   <= 1'b0;
      out_last    <= (rd_idx == count);
      out_count   <= COUNT_W'(count);
    end else if (cmd.emit_reply) begin
      out_status  <= status;
      out_found   <= found;
      out_element <= '0;
      out_empty   <= (action == ACT_SHOW);
      out_last    <= 1'b1;
      out_count   <= COUNT_W'(count);
    end
  end

endmodule

[design/compacting_vector_table.sv]
// Appends, bad-index removes and an empty show go from dispatch straight to the reply state.
// Find and remove walk the stored entries through one memory read port before replying.
// Show alternates read and emit states, presenting one element each time the output is free.
// Requests are taken one at a time; the next is accepted only once the controller is idle.
// Synchronous active-high rst clears the count, the controller and the output valid.
// Entry contents are not cleared; only entries below the count are ever read.
module compacting_vector_table (
  input logic clk,
  input logic rst,
  cvt_req_if.sink   req,
  cvt_rsp_if.source rsp
);
  import cvt_pkg::*;

  // The controller and datapath talk only through these two bundles.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the request handshake: a request is taken only when the
  // block is idle, and the datapath latches it in that same cycle.
  cvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entry memory and the result register. Scans stream
  // reads one per cycle, and remove scans write survivors back behind the read
  // pointer, so a compaction never overwrites an entry that is still to be read.
  cvt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action_in   (req.action),
    .value_in    (req.value),
    .position_in (req.position_in),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_found   (rsp.found_position),
    .out_element (rsp.element),
    .out_empty   (rsp.is_empty),
    .out_last    (rsp.last),
    .out_count   (rsp.count_out)
  );

endmodule

[design/cvt_checker.sv]
// Port-level checker for the compacting vector table and its bind.
`include "compacting_vector_table_defines.svh"

module cvt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic        [cvt_pkg::STATUS_W-1:0] rsp_status,
  input logic signed [cvt_pkg::FOUND_W-1:0]  rsp_found,
  input logic signed [cvt_pkg::VALUE_W-1:0]  rsp_element,
  input logic                                rsp_empty,
  input logic                                rsp_last,
  input logic        [cvt_pkg::COUNT_W-1:0]  rsp_count
);
  import cvt_pkg::*;

  `CVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_element) && $stable(rsp_last), "stalled result changed")
  `CVT_ASSERT_NOW(a_empty_show, rsp_valid && rsp_empty, rsp_last && (rsp_count == '0) && (rsp_element == '0), "empty show result malformed")
  `CVT_ASSERT_NOW(a_count_bound, rsp_valid, rsp_count <= COUNT_W'(DEPTH), "count beyond table depth")
  `CVT_ASSERT_NOW(a_fail_single, rsp_valid && (rsp_status != STATUS_OK), rsp_last && (rsp_found == '0) && (rsp_element == '0), "failed request result malformed")
  `CVT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind compacting_vector_table cvt_checker u_cvt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_found   (rsp.found_position),
  .rsp_element (rsp.element),
  .rsp_empty   (rsp.is_empty),
  .rsp_last    (rsp.last),
  .rsp_count   (rsp.count_out)
);
